[src/bhc_pkg.sv]
`timescale 1ns / 1ps

package bhc_pkg;

  // Item opcodes.
  typedef enum logic [1:0] {
    OpHallEdge    = 2'd0,
    OpSpeedTick   = 2'd1,
    OpStartSample = 2'd2,
    OpStopClear   = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CfgRpmPerEdge  = 1'b0;
  localparam cfg_idx_t CfgCountsPerRev = 1'b1;

  typedef logic [2:0]  hall_t;
  typedef logic [1:0]  phase_t;
  typedef logic [19:0] rpe_t;
  typedef logic [9:0]  cpr_t;

  localparam rpe_t  RpeReset   = 20'd40000;
  localparam cpr_t  CprReset   = 10'd24;
  localparam hall_t HallNone   = 3'd7;

  // Filter coefficients 0.8519 and 0.07407 in Q16.
  localparam logic [15:0] CoefFbQ16 = 16'd55830;
  localparam logic [15:0] CoefFfQ16 = 16'd4854;

  // Forward successor of a Hall state, zero when there is none.
  function automatic hall_t bhc_fwd_succ(input hall_t h);
    hall_t s;
    case (h)
      3'd1:    s = 3'd5;
      3'd2:    s = 3'd3;
      3'd3:    s = 3'd1;
      3'd4:    s = 3'd6;
      3'd5:    s = 3'd4;
      3'd6:    s = 3'd2;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // Backward successor of a Hall state, zero when there is none.
  function automatic hall_t bhc_bwd_succ(input hall_t h);
    hall_t s;
    case (h)
      3'd1:    s = 3'd3;
      3'd2:    s = 3'd6;
      3'd3:    s = 3'd2;
      3'd4:    s = 3'd5;
      3'd5:    s = 3'd1;
      3'd6:    s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // Six-step pattern {high, low} for clockwise drive.
  function automatic logic [3:0] bhc_pat_cw(input hall_t h);
    logic [3:0] p;
    case (h)
      3'd1:    p = 4'h2;
      3'd2:    p = 4'h4;
      3'd3:    p = 4'h6;
      3'd4:    p = 4'h9;
      3'd5:    p = 4'h1;
      3'd6:    p = 4'h8;
      default: p = 4'h0;
    endcase
    return p;
  endfunction

  // Six-step pattern {high, low} for counter-clockwise drive.
  function automatic logic [3:0] bhc_pat_ccw(input hall_t h);
    logic [3:0] p;
    case (h)
      3'd1:    p = 4'h8;
      3'd2:    p = 4'h1;
      3'd3:    p = 4'h9;
      3'd4:    p = 4'h6;
      3'd5:    p = 4'h4;
      3'd6:    p = 4'h2;
      default: p = 4'h0;
    endcase
    return p;
  endfunction

endpackage

[src/bhc_if.sv]
`timescale 1ns / 1ps

// Input item channel.
interface bhc_item_if;
  import bhc_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  hall_t      hall_bits;
  logic       drive_ccw;
  modport source (output valid, opcode, hall_bits, drive_ccw, input ready);
  modport sink (input valid, opcode, hall_bits, drive_ccw, output ready);
endinterface

// Result channel.
interface bhc_result_if;
  import bhc_pkg::*;
  logic               valid;
  logic               ready;
  phase_t             high_phase;
  phase_t             low_phase;
  logic               drive_known;
  logic               rotation_ccw;
  logic signed [15:0] speed_rpm;
  logic signed [15:0] revolutions;
  modport source (output valid, high_phase, low_phase, drive_known, rotation_ccw,
                  speed_rpm, revolutions, input ready);
  modport sink (input valid, high_phase, low_phase, drive_known, rotation_ccw,
                speed_rpm, revolutions, output ready);
endinterface

// Configuration write channel.
interface bhc_cfg_if;
  import bhc_pkg::*;
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/bldc_hall_commutator_speed_estimator_core.sv]
`timescale 1ns / 1ps

// Six-step Hall commutator with speed and position estimator.
// item_i carries one beat per event: Hall edge, speed tick, start sample or
// stop clear. Every accepted beat produces exactly one beat on result_o with
// the drive pattern, measured direction, filtered speed and revolutions.
// cfg_i writes rpm_per_edge_q8 (index 0) and counts_per_rev (index 1); it is
// always ready. It is to be used only while the block is idle; the block
// itself does not enforce this. Hall, start and stop beats update the state
// in the accept cycle; the emit state then loads the result into the output
// register, and the next beat is taken once the block is back in idle. A
// speed tick runs a bit-serial multiply over the edge-count bits, a saturate
// step, a pre-add step, a bit-serial filter multiply over the coefficient
// bits and the finishing steps StFin and StOut before its result is emitted.
// The restoring divider for revolutions runs alongside the speed path.
// One beat is worked on at a time. A finished result waits in the output
// register while the receiver stalls; a new item is taken meanwhile, but
// its result is held back until the output register is free. Reset loads
// the register defaults, clears counters, filter and outputs, marks the
// drive as unknown and sets the previous Hall state to 7.
module bldc_hall_commutator_speed_estimator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  bhc_item_if.sink   item_i,
  bhc_result_if.source result_o,
  bhc_cfg_if.sink    cfg_i
);
  import bhc_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StSat,
    StSum,
    StFilt,
    StFin,
    StOut,
    StEmit
  } st_e;

  st_e state_q;
  logic [3:0] cnt_q;

  // Configuration.
  rpe_t rpe_q;
  cpr_t cpr_q;

  // Model state.
  hall_t        prev_hall_q;
  logic         dir_q;
  logic [15:0]  edge_q;
  logic [31:0]  pos_q;
  logic [31:0]  raw_prev_q;
  logic [31:0]  filt_q;
  logic [15:0]  speed_q;
  logic [15:0]  revs_q;
  logic         drive_known_q;
  phase_t       drive_hi_q;
  phase_t       drive_lo_q;

  // Tick datapath.
  logic [35:0]  hi_q;
  logic [15:0]  lo_q;
  logic [31:0]  raw_q;
  logic [32:0]  sum_q;
  logic [15:0]  cfb_q;
  logic [15:0]  cff_q;

  // Divider.
  logic         div_busy_q;
  logic [4:0]   div_cnt_q;
  logic [31:0]  div_q;
  logic [9:0]   div_rem_q;
  logic         div_neg_q;

  // Output register.
  logic         out_valid_q;

  logic         accept;
  logic         emit;
  op_e          op;
  hall_t        h_in;
  hall_t        f_succ;
  hall_t        b_succ;
  logic         step_fwd;
  logic         step_bwd;
  logic         pat_ok;
  logic [3:0]   pat;
  logic [31:0]  pos_hall;
  logic         dir_hall;
  logic [20:0]  mul_sum;
  logic [35:0]  mag;
  logic [35:0]  mag_neg;
  logic [31:0]  raw_sat;
  logic [32:0]  sum_raw;
  logic [35:0]  addend;
  logic [35:0]  psum;
  logic [35:0]  fin_sum;
  logic [31:0]  filt_sat;
  logic [32:0]  filt_bias;
  logic [24:0]  spd;
  logic [15:0]  speed_sat;
  logic [15:0]  revs_sat;
  logic [15:0]  quot_neg;
  cpr_t         dvsr;
  logic [10:0]  div_t;
  logic         div_ge;
  logic [10:0]  div_diff;

  assign item_i.ready = (state_q == StIdle);
  assign cfg_i.ready  = 1'b1;
  assign accept       = item_i.valid && item_i.ready;
  assign op           = op_e'(item_i.opcode);
  assign h_in         = item_i.hall_bits;
  assign result_o.valid = out_valid_q;
  assign emit         = (state_q == StEmit) && (!out_valid_q || result_o.ready);

  // Hall step: direction, position count and drive pattern.
  always_comb begin
    f_succ   = bhc_fwd_succ(prev_hall_q);
    b_succ   = bhc_bwd_succ(prev_hall_q);
    step_fwd = (f_succ != 3'd0) && (h_in == f_succ);
    step_bwd = !step_fwd && (b_succ != 3'd0) && (h_in == b_succ);
    pat_ok   = (h_in != 3'd0) && (h_in != 3'd7);
    pat      = item_i.drive_ccw ? bhc_pat_ccw(h_in) : bhc_pat_cw(h_in);
    dir_hall = dir_q;
    pos_hall = pos_q;
    if (step_fwd) begin
      dir_hall = 1'b0;
      if (pos_q != 32'h7FFF_FFFF) pos_hall = pos_q + 32'd1;
    end else if (step_bwd) begin
      dir_hall = 1'b1;
      if (pos_q != 32'h8000_0000) pos_hall = pos_q - 32'd1;
    end
  end

  // Speed path: serial multiply step, saturation, pre-add, filter step.
  always_comb begin
    mul_sum = {1'b0, hi_q[19:0]} + (edge_q[0] ? {1'b0, rpe_q} : 21'd0);
    mag     = {hi_q[19:0], lo_q};
    mag_neg = ~mag + 36'd1;
    if (dir_q) begin
      raw_sat = (mag > 36'h0_8000_0000) ? 32'h8000_0000 : mag_neg[31:0];
    end else begin
      raw_sat = (mag > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    sum_raw = {raw_q[31], raw_q} + {raw_prev_q[31], raw_prev_q};
    addend  = (cfb_q[0] ? {{4{filt_q[31]}}, filt_q} : 36'd0)
            + (cff_q[0] ? {{3{sum_q[32]}}, sum_q} : 36'd0);
    psum    = hi_q + addend;
  end

  // Finishing: rounding, saturation, scaling to rpm and signed quotient.
  always_comb begin
    fin_sum = hi_q + {35'd0, lo_q[15]};
    if ($signed(fin_sum) > $signed(36'h0_7FFF_FFFF)) begin
      filt_sat = 32'h7FFF_FFFF;
    end else if ($signed(fin_sum) < $signed(36'hF_8000_0000)) begin
      filt_sat = 32'h8000_0000;
    end else begin
      filt_sat = fin_sum[31:0];
    end
    // Division by 256 truncating toward zero.
    filt_bias = {filt_q[31], filt_q} + (filt_q[31] ? 33'd255 : 33'd0);
    spd       = filt_bias[32:8];
    if ($signed(spd) > $signed(25'h000_7FFF)) begin
      speed_sat = 16'h7FFF;
    end else if ($signed(spd) < $signed(25'h1FF_8000)) begin
      speed_sat = 16'h8000;
    end else begin
      speed_sat = spd[15:0];
    end
    quot_neg = ~div_q[15:0] + 16'd1;
    if (div_neg_q) begin
      revs_sat = (div_q > 32'd32768) ? 16'h8000 : quot_neg;
    end else begin
      revs_sat = (div_q > 32'd32767) ? 16'h7FFF : div_q[15:0];
    end
  end

  // Restoring divider step.
  always_comb begin
    dvsr     = (cpr_q == 10'd0) ? 10'd1 : cpr_q;
    div_t    = {div_rem_q, div_q[31]};
    div_ge   = div_t >= {1'b0, dvsr};
    div_diff = div_t - {1'b0, dvsr};
  end

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      cnt_q         <= '0;
      rpe_q         <= RpeReset;
      cpr_q         <= CprReset;
      prev_hall_q   <= HallNone;
      dir_q         <= 1'b0;
      edge_q        <= '0;
      pos_q         <= '0;
      raw_prev_q    <= '0;
      filt_q        <= '0;
      speed_q       <= '0;
      revs_q        <= '0;
      drive_known_q <= 1'b0;
      drive_hi_q    <= '0;
      drive_lo_q    <= '0;
      hi_q          <= '0;
      lo_q          <= '0;
      raw_q         <= '0;
      sum_q         <= '0;
      cfb_q         <= '0;
      cff_q         <= '0;
      div_busy_q    <= 1'b0;
      div_cnt_q     <= '0;
      div_q         <= '0;
      div_rem_q     <= '0;
      div_neg_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      result_o.high_phase   <= '0;
      result_o.low_phase    <= '0;
      result_o.drive_known  <= 1'b0;
      result_o.rotation_ccw <= 1'b0;
      result_o.speed_rpm    <= '0;
      result_o.revolutions  <= '0;
    end else begin
      // Configuration writes.
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CfgRpmPerEdge:   rpe_q <= cfg_i.data;
          CfgCountsPerRev: cpr_q <= cfg_i.data[9:0];
          default:         rpe_q <= rpe_q;
        endcase
      end

      // Output valid: set by a new result, cleared when the beat is taken.
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      // Divider runs alongside the speed path.
      if (div_busy_q) begin
        div_rem_q <= div_ge ? div_diff[9:0] : div_t[9:0];
        div_q     <= {div_q[30:0], div_ge};
        div_cnt_q <= div_cnt_q + 5'd1;
        if (div_cnt_q == 5'd31) div_busy_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            case (op)
              OpHallEdge, OpStartSample: begin
                if (op == OpHallEdge && edge_q != 16'hFFFF) edge_q <= edge_q + 16'd1;
                prev_hall_q <= h_in;
                dir_q       <= dir_hall;
                pos_q       <= pos_hall;
                if (pat_ok) begin
                  drive_known_q <= 1'b1;
                  drive_hi_q    <= pat[3:2];
                  drive_lo_q    <= pat[1:0];
                end
                state_q <= StEmit;
              end
              OpSpeedTick: begin
                hi_q       <= '0;
                lo_q       <= '0;
                cnt_q      <= '0;
                div_busy_q <= 1'b1;
                div_cnt_q  <= '0;
                div_rem_q  <= '0;
                div_neg_q  <= pos_q[31];
                div_q      <= pos_q[31] ? (~pos_q + 32'd1) : pos_q;
                state_q    <= StMul;
              end
              OpStopClear: begin
                edge_q  <= '0;
                pos_q   <= '0;
                speed_q <= '0;
                revs_q  <= '0;
                state_q <= StEmit;
              end
              default: state_q <= StEmit;
            endcase
          end
        end
        // Edge count times rpm per edge, one multiplier bit a cycle; the
        // edge count shifts out and is left cleared.
        StMul: begin
          hi_q   <= {16'd0, mul_sum[20:1]};
          lo_q   <= {mul_sum[0], lo_q[15:1]};
          edge_q <= {1'b0, edge_q[15:1]};
          cnt_q  <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) state_q <= StSat;
        end
        StSat: begin
          raw_q   <= raw_sat;
          state_q <= StSum;
        end
        StSum: begin
          sum_q      <= sum_raw;
          raw_prev_q <= raw_q;
          hi_q       <= '0;
          lo_q       <= '0;
          cfb_q      <= CoefFbQ16;
          cff_q      <= CoefFfQ16;
          cnt_q      <= '0;
          state_q    <= StFilt;
        end
        // Filter products, one coefficient bit a cycle, LSB first.
        StFilt: begin
          hi_q  <= {psum[35], psum[35:1]};
          lo_q  <= {psum[0], lo_q[15:1]};
          cfb_q <= {1'b0, cfb_q[15:1]};
          cff_q <= {1'b0, cff_q[15:1]};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) state_q <= StFin;
        end
        StFin: begin
          filt_q  <= filt_sat;
          state_q <= StOut;
        end
        StOut: begin
          speed_q <= speed_sat;
          revs_q  <= revs_sat;
          state_q <= StEmit;
        end
        StEmit: begin
          if (emit) begin
            result_o.high_phase   <= drive_known_q ? drive_hi_q : 2'd0;
            result_o.low_phase    <= drive_known_q ? drive_lo_q : 2'd0;
            result_o.drive_known  <= drive_known_q;
            result_o.rotation_ccw <= dir_q;
            result_o.speed_rpm    <= speed_q;
            result_o.revolutions  <= revs_q;
            state_q               <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A speed tick always starts the serial multiply.
  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.opcode == OpSpeedTick) |=> (state_q == StMul && div_busy_q))
    else $error("speed tick did not start the multiply and divide");

  // The quotient must be final before revolutions are taken from it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |-> !div_busy_q)
    else $error("divider still busy when revolutions are updated");

  // Once a valid Hall state has set the drive, it stays known.
  a_known_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(drive_known_q))
    else $error("drive pattern lost its known flag");

  // A free output register always takes the pending result.
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && (!out_valid_q || result_o.ready))
      |=> (out_valid_q && state_q == StIdle))
    else $error("pending result was not loaded into the output register");
`endif

endmodule
